>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the buddy allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define BTPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain invariant checked at every rising clock edge outside reset.
`define BTPA_INVARIANT(lbl, clk, rst_n, expr, msg) \
    `BTPA_ASSERT(lbl, clk, rst_n, (expr), msg)

`endif

>>> src/btpa_pkg.sv
// ----------------------------------------------------------------------------
// btpa_pkg
// Shared types and constants of the buddy tree page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btpa_pkg;

    localparam int MAX_PAGES     = 1024;
    localparam int PW            = 11;   // page count field width
    localparam int OW            = 10;   // page offset field width
    localparam int LG_W          = 5;    // log2 of a block size
    localparam int POOL_RESET_LG = 10;   // pool of 1024 pages after reset

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_A_ROOT,
        S_A_CHK,
        S_RL,
        S_RR,
        S_DEC,
        S_MARK,
        S_F_CHK,
        S_F_RD,
        S_F_TST,
        S_URD,
        S_UWR,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_SWEEP,
        UOP_LOAD,
        UOP_RD_ROOT,
        UOP_RD_LEFT,
        UOP_RD_RIGHT,
        UOP_DESCEND,
        UOP_MARK,
        UOP_FREE_IDX,
        UOP_RD_NODE,
        UOP_RESTORE,
        UOP_RD_SIB,
        UOP_CLIMB,
        UOP_FAIL,
        UOP_FINISH
    } t_uop;

    typedef struct packed {
        t_uop    uop;
        t_status fail_code;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
        logic alloc_bad;
        logic geom_bad;
        logic node_used;
        logic at_target;
        logic next_target;
        logic at_root;
        logic parent_root;
    } t_stat;

endpackage

`default_nettype wire

>>> src/buddy_tree_page_allocator_top.sv
// Alloc: per tree level going down a left read, a right read and a descent step, and per
// level going up a sibling read and a write, as the tree memory has a single read port.
// Free: checks, a node read and test, a sibling read and write per level climbed, a finish.
// One transaction at a time; a finished result waits in the output register.
// After reset and after each pool write the tree is rebuilt by a sweep that writes
// all 2*P_MAX_PAGES-1 tree nodes, during which no request is taken.
// ----------------------------------------------------------------------------
// buddy_tree_page_allocator_top
// Binary buddy page allocator with a largest-free tree in block memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buddy_tree_page_allocator_top #(
    parameter int P_MAX_PAGES = btpa_pkg::MAX_PAGES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [btpa_pkg::PW-1:0] i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_req_type,
    input  wire logic [btpa_pkg::PW-1:0] i_req_pages,
    input  wire logic [btpa_pkg::OW-1:0] i_block_offset,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [1:0]                   o_status,
    output logic [btpa_pkg::OW-1:0]      o_alloc_offset,
    output logic [btpa_pkg::PW-1:0]      o_free_page_count
);
    import btpa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    btpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_ready    (o_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    btpa_datapath #(
        .P_MAX_PAGES (P_MAX_PAGES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_req_pages       (i_req_pages),
        .i_block_offset    (i_block_offset),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_alloc_offset    (o_alloc_offset),
        .o_free_page_count (o_free_page_count)
    );

endmodule

`default_nettype wire

>>> src/btpa_datapath.sv
// ----------------------------------------------------------------------------
// btpa_datapath
// Tree memory, request registers, size and index arithmetic, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btpa_datapath #(
    parameter int P_MAX_PAGES = btpa_pkg::MAX_PAGES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire btpa_pkg::t_cmd        i_cmd,
    output btpa_pkg::t_stat            o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [btpa_pkg::PW-1:0] i_cfg_data,
    input  wire logic                  i_req_type,
    input  wire logic [btpa_pkg::PW-1:0] i_req_pages,
    input  wire logic [btpa_pkg::OW-1:0] i_block_offset,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [1:0]                 o_status,
    output logic [btpa_pkg::OW-1:0]    o_alloc_offset,
    output logic [btpa_pkg::PW-1:0]    o_free_page_count
);
    import btpa_pkg::*;

    localparam int DEPTH  = 2 * P_MAX_PAGES - 1;
    localparam int NODE_W = $clog2(DEPTH);
    localparam int MAXLG  = $clog2(P_MAX_PAGES);
    localparam int VW     = MAXLG + 1;
    localparam int SZ_W   = VW + 1;
    localparam int CW     = SZ_W + OW;
    localparam int RST_LG = (POOL_RESET_LG > MAXLG) ? MAXLG : POOL_RESET_LG;

    function automatic logic [LG_W-1:0] hibit(input logic [PW-1:0] v);
        logic [LG_W-1:0] h;
        h = '0;
        for (int i = 0; i < PW; i++) begin
            if (v[i]) h = LG_W'(i);
        end
        return h;
    endfunction

    logic [VW-1:0]     mem [DEPTH];
    logic [VW-1:0]     r_rd;
    logic [VW-1:0]     r_l;
    logic [LG_W-1:0]   r_pool_lg;
    logic [NODE_W-1:0] r_sw_i;
    logic [VW-1:0]     r_sw_sz;
    logic [NODE_W:0]   r_sw_last;
    logic [VW-1:0]     r_cnt;
    logic [LG_W-1:0]   r_size_lg;
    logic [LG_W-1:0]   r_node_lg;
    logic [OW-1:0]     r_boff;
    logic              r_is_free;
    logic [NODE_W-1:0] r_idx;
    logic [VW-1:0]     r_v;
    logic [OW-1:0]     r_off;
    t_status           r_st;
    logic              r_o_valid;
    logic [1:0]        r_o_status;
    logic [OW-1:0]     r_o_off;
    logic [PW-1:0]     r_o_cnt;

    logic [LG_W-1:0]   cfg_lg;
    logic [LG_W-1:0]   req_lg;
    logic [CW-1:0]     size_c;
    logic [CW-1:0]     pool_c;
    logic [CW-1:0]     boff_c;
    logic [NODE_W-1:0] left_idx;
    logic [NODE_W-1:0] right_idx;
    logic [NODE_W-1:0] sib_idx;
    logic [NODE_W-1:0] parent_idx;
    logic [NODE_W-1:0] free_idx;
    logic [NODE_W-1:0] raddr;
    logic [NODE_W-1:0] waddr;
    logic [VW-1:0]     wdata;
    logic              we;
    logic              l_fit;
    logic              r_fit;
    logic [NODE_W-1:0] down_idx;
    logic [CW-1:0]     off_full;
    logic [CW-1:0]     merge_sum;
    logic [CW-1:0]     merge_full;
    logic [VW-1:0]     climb_v;
    logic [CW-1:0]     cnt_sum;
    logic [VW-1:0]     cnt_next;

    always_comb begin
        cfg_lg = hibit(i_cfg_data);
        if (cfg_lg > LG_W'(MAXLG)) cfg_lg = LG_W'(MAXLG);
        req_lg = (i_req_pages <= PW'(1)) ? '0 : hibit(i_req_pages - PW'(1)) + LG_W'(1);
    end

    assign size_c     = CW'(1) << r_size_lg;
    assign pool_c     = CW'(1) << r_pool_lg;
    assign boff_c     = CW'(r_boff);
    assign left_idx   = NODE_W'({r_idx, 1'b0} + (NODE_W + 1)'(1));
    assign right_idx  = NODE_W'({r_idx, 1'b0} + (NODE_W + 1)'(2));
    assign sib_idx    = r_idx[0] ? r_idx + NODE_W'(1) : r_idx - NODE_W'(1);
    assign parent_idx = (r_idx - NODE_W'(1)) >> 1;
    assign free_idx   = NODE_W'((CW'(1) << (r_pool_lg - r_size_lg)) - CW'(1)
                                + (boff_c >> r_size_lg));

    // descent choice: both fit -> tighter child, left on a tie
    assign l_fit = CW'(r_l) >= size_c;
    assign r_fit = CW'(r_rd) >= size_c;
    always_comb begin
        if (l_fit && r_fit) down_idx = (r_l <= r_rd) ? left_idx : right_idx;
        else if (l_fit)     down_idx = left_idx;
        else                down_idx = right_idx;
    end

    assign off_full   = (CW'(r_idx) + CW'(1)) << r_node_lg;
    assign merge_sum  = CW'(r_v) + CW'(r_rd);
    assign merge_full = CW'(1) << (r_node_lg + LG_W'(1));
    always_comb begin
        if (r_is_free && merge_sum == merge_full) climb_v = VW'(merge_full);
        else climb_v = (r_v > r_rd) ? r_v : r_rd;
    end

    always_comb begin
        cnt_sum = CW'(r_cnt) + size_c;
        if (r_st != ST_OK)  cnt_next = r_cnt;
        else if (r_is_free) cnt_next = (cnt_sum > pool_c) ? VW'(pool_c) : VW'(cnt_sum);
        else cnt_next = (CW'(r_cnt) >= size_c) ? VW'(CW'(r_cnt) - size_c) : '0;
    end

    always_comb begin
        raddr = '0;
        we    = 1'b0;
        waddr = r_idx;
        wdata = '0;
        case (i_cmd.uop)
            UOP_RD_LEFT:  raddr = left_idx;
            UOP_RD_RIGHT: raddr = right_idx;
            UOP_RD_NODE:  raddr = r_idx;
            UOP_RD_SIB:   raddr = sib_idx;
            UOP_SWEEP: begin
                we    = 1'b1;
                waddr = r_sw_i;
                wdata = r_sw_sz;
            end
            UOP_MARK:     we = 1'b1;
            UOP_RESTORE: begin
                we    = 1'b1;
                wdata = VW'(size_c);
            end
            UOP_CLIMB: begin
                we    = 1'b1;
                waddr = parent_idx;
                wdata = climb_v;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[raddr];
    end

    // pool, sweep and free count: control state, restarted on config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_lg <= LG_W'(RST_LG);
            r_sw_i    <= '0;
            r_sw_sz   <= VW'(1) << RST_LG;
            r_sw_last <= '0;
            r_cnt     <= VW'(1) << RST_LG;
        end else if (i_cfg_we) begin
            r_pool_lg <= cfg_lg;
            r_sw_i    <= '0;
            r_sw_sz   <= VW'(1) << cfg_lg;
            r_sw_last <= '0;
            r_cnt     <= VW'(1) << cfg_lg;
        end else if (i_cmd.uop == UOP_SWEEP) begin
            r_sw_i <= r_sw_i + NODE_W'(1);
            if ({1'b0, r_sw_i} == r_sw_last) begin
                r_sw_sz   <= r_sw_sz >> 1;
                r_sw_last <= (NODE_W + 1)'({r_sw_last, 1'b0} + (NODE_W + 2)'(2));
            end
        end else if (i_cmd.uop == UOP_FINISH) begin
            r_cnt <= cnt_next;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            UOP_LOAD: begin
                r_size_lg <= req_lg;
                r_boff    <= i_block_offset;
                r_is_free <= i_req_type;
                r_st      <= ST_OK;
                r_idx     <= '0;
                r_node_lg <= i_req_type ? req_lg : r_pool_lg;
                r_off     <= '0;
            end
            UOP_RD_RIGHT: r_l <= r_rd;
            UOP_DESCEND: begin
                r_idx     <= down_idx;
                r_node_lg <= r_node_lg - LG_W'(1);
            end
            UOP_MARK: begin
                r_v   <= '0;
                r_off <= OW'(off_full - pool_c);
            end
            UOP_FREE_IDX: r_idx <= free_idx;
            UOP_RESTORE:  r_v <= VW'(size_c);
            UOP_CLIMB: begin
                r_v       <= climb_v;
                r_idx     <= parent_idx;
                r_node_lg <= r_node_lg + LG_W'(1);
            end
            UOP_FAIL: r_st <= i_cmd.fail_code;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.uop == UOP_FINISH) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == UOP_FINISH) begin
            r_o_status <= r_st;
            r_o_off    <= (r_st == ST_OK && !r_is_free) ? r_off : '0;
            r_o_cnt    <= PW'(cnt_next);
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_alloc_offset    = r_o_off;
    assign o_free_page_count = r_o_cnt;

    always_comb begin
        o_stat.sweep_last  = (r_sw_i == NODE_W'(DEPTH - 1));
        o_stat.out_free    = !r_o_valid || i_ready;
        o_stat.alloc_bad   = (r_size_lg > r_pool_lg) || (CW'(r_rd) < size_c);
        o_stat.geom_bad    = (r_size_lg > r_pool_lg)
                          || ((boff_c & (size_c - CW'(1))) != '0)
                          || (boff_c + size_c > pool_c);
        o_stat.node_used   = (r_rd != '0);
        o_stat.at_target   = (r_node_lg == r_size_lg);
        o_stat.next_target = (r_node_lg == r_size_lg + LG_W'(1));
        o_stat.at_root     = (r_idx == '0);
        o_stat.parent_root = (r_idx <= NODE_W'(2));
    end

    `BTPA_INVARIANT(a_cnt_le_pool, i_clk, i_rst_n, CW'(r_cnt) <= pool_c, "free count above pool")
    `BTPA_ASSERT(a_mark_level, i_clk, i_rst_n, (i_cmd.uop == UOP_MARK) |-> (r_node_lg == r_size_lg), "allocation marked at wrong level")

endmodule

`default_nettype wire

>>> src/btpa_ctrl.sv
// ----------------------------------------------------------------------------
// btpa_ctrl
// Sequencer for tree sweep, allocation descent, free check and climb.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btpa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_valid,
    input  wire logic            i_req_type,
    output logic                 o_ready,
    input  wire btpa_pkg::t_stat i_stat,
    output btpa_pkg::t_cmd       o_cmd
);
    import btpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_SWEEP;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP:  if (i_stat.sweep_last) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = i_req_type ? S_F_CHK : S_A_ROOT;
            S_A_ROOT: n_state = S_A_CHK;
            S_A_CHK: begin
                if (i_stat.alloc_bad)      n_state = S_FIN;
                else if (i_stat.at_target) n_state = S_MARK;
                else                       n_state = S_RL;
            end
            S_RL:     n_state = S_RR;
            S_RR:     n_state = S_DEC;
            S_DEC:    n_state = i_stat.next_target ? S_MARK : S_RL;
            S_MARK:   n_state = i_stat.at_root ? S_FIN : S_URD;
            S_F_CHK:  n_state = i_stat.geom_bad ? S_FIN : S_F_RD;
            S_F_RD:   n_state = S_F_TST;
            S_F_TST: begin
                if (i_stat.node_used)    n_state = S_FIN;
                else if (i_stat.at_root) n_state = S_FIN;
                else                     n_state = S_URD;
            end
            S_URD:    n_state = S_UWR;
            S_UWR:    n_state = i_stat.parent_root ? S_FIN : S_URD;
            S_FIN:    if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_SWEEP;
        endcase
        // rebuild the tree after a pool change
        if (i_cfg_we) n_state = S_SWEEP;
    end

    always_comb begin
        o_cmd.uop       = UOP_NONE;
        o_cmd.fail_code = ST_BADFREE;
        unique case (r_state)
            S_SWEEP:  o_cmd.uop = UOP_SWEEP;
            S_IDLE:   if (i_valid) o_cmd.uop = UOP_LOAD;
            S_A_ROOT: o_cmd.uop = UOP_RD_ROOT;
            S_A_CHK: begin
                o_cmd.fail_code = ST_NOSPACE;
                if (i_stat.alloc_bad) o_cmd.uop = UOP_FAIL;
            end
            S_RL:     o_cmd.uop = UOP_RD_LEFT;
            S_RR:     o_cmd.uop = UOP_RD_RIGHT;
            S_DEC:    o_cmd.uop = UOP_DESCEND;
            S_MARK:   o_cmd.uop = UOP_MARK;
            S_F_CHK:  o_cmd.uop = i_stat.geom_bad ? UOP_FAIL : UOP_FREE_IDX;
            S_F_RD:   o_cmd.uop = UOP_RD_NODE;
            S_F_TST:  o_cmd.uop = i_stat.node_used ? UOP_FAIL : UOP_RESTORE;
            S_URD:    o_cmd.uop = UOP_RD_SIB;
            S_UWR:    o_cmd.uop = UOP_CLIMB;
            S_FIN:    if (i_stat.out_free) o_cmd.uop = UOP_FINISH;
            default:  o_cmd.uop = UOP_NONE;
        endcase
        if (i_cfg_we) o_cmd.uop = UOP_NONE;
    end

    assign o_ready = (r_state == S_IDLE) && !i_cfg_we;

    `BTPA_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state != S_IDLE), "accepted transaction left no work")
    `BTPA_ASSERT(a_sweep_done, i_clk, i_rst_n, (r_state == S_SWEEP && i_stat.sweep_last && !i_cfg_we) |=> (r_state == S_IDLE), "sweep did not end")

endmodule

`default_nettype wire

>>> tb/sv/buddy_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_alloc_checker
// Watches the request and response channels, predicts every response from a
// local model of the largest-free tree, and counts mismatches.
// ----------------------------------------------------------------------------
module buddy_alloc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    input  logic        i_req_fire,
    input  logic        i_req_type,
    input  logic [10:0] i_req_pages,
    input  logic [9:0]  i_block_offset,
    input  logic        i_rsp_fire,
    input  logic [1:0]  i_status,
    input  logic [9:0]  i_alloc_offset,
    input  logic [10:0] i_free_page_count,
    output int          o_fail_count,
    output int          o_pending
);
    import btpa_pkg::*;

    localparam int NODES = 2 * MAX_PAGES - 1;

    typedef struct packed {
        t_status     status;
        logic [9:0]  offset;
        logic [10:0] count;
    } t_alloc_rsp;

    logic [10:0] longest [NODES];
    int unsigned pool;
    int unsigned model_free;
    t_alloc_rsp  rsp_queue [$];

    assign o_pending = rsp_queue.size();

    task automatic rebuild_tree(input int unsigned raw);
        int unsigned p;
        int unsigned sz;
        p = 1;
        if (raw == 0) raw = 1;
        if (raw > MAX_PAGES) raw = MAX_PAGES;
        while ((p << 1) <= raw) p <<= 1;
        pool = p;
        sz = 2 * p;
        for (int i = 0; i < NODES; i++) begin
            if (((i + 1) & i) == 0) sz = sz / 2;
            longest[i] = (i < 2 * p - 1) ? sz[10:0] : 11'd0;
        end
        model_free = p;
    endtask

    function automatic int unsigned max2(input int unsigned a, input int unsigned b);
        return a > b ? a : b;
    endfunction

    task automatic serve_request(input logic typ, input int unsigned pages,
                                 input int unsigned boff);
        int unsigned sz, idx, nsz, l, r;
        t_alloc_rsp e;
        sz = 1;
        e.status = ST_OK;
        e.offset = '0;
        while (sz < pages) sz <<= 1;
        if (!typ) begin
            if (sz > pool || longest[0] < sz) begin
                e.status = ST_NOSPACE;
            end else begin
                idx = 0;
                for (nsz = pool; nsz > sz && 2 * idx + 2 < NODES; nsz = nsz / 2) begin
                    l = longest[2 * idx + 1];
                    r = longest[2 * idx + 2];
                    if (l >= sz && r >= sz) idx = (l <= r) ? 2 * idx + 1 : 2 * idx + 2;
                    else if (l >= sz) idx = 2 * idx + 1;
                    else idx = 2 * idx + 2;
                end
                longest[idx] = '0;
                e.offset = 10'((idx + 1) * nsz - pool);
                while (idx != 0) begin
                    idx = (idx + 1) / 2 - 1;
                    longest[idx] = 11'(max2(longest[2 * idx + 1], longest[2 * idx + 2]));
                end
                model_free = (model_free >= sz) ? model_free - sz : 0;
            end
        end else begin
            if (sz > pool || (boff & (sz - 1)) != 0 || boff + sz > pool) begin
                e.status = ST_BADFREE;
            end else begin
                idx = pool / sz - 1 + boff / sz;
                if (idx >= NODES || longest[idx] != 0) begin
                    e.status = ST_BADFREE;
                end else begin
                    longest[idx] = 11'(sz);
                    nsz = sz;
                    while (idx != 0) begin
                        idx = (idx + 1) / 2 - 1;
                        nsz *= 2;
                        l = longest[2 * idx + 1];
                        r = longest[2 * idx + 2];
                        longest[idx] = 11'((l + r == nsz) ? nsz : max2(l, r));
                    end
                    model_free += sz;
                    if (model_free > pool) model_free = pool;
                end
            end
        end
        e.count = 11'(model_free);
        rsp_queue.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_alloc_rsp e;
        if (!i_rst_n) begin
            rebuild_tree(1024);
            rsp_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) rebuild_tree(i_cfg_data);
            if (i_req_fire) serve_request(i_req_type, i_req_pages, i_block_offset);
            if (i_rsp_fire) begin
                if (rsp_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected response status=%0d off=%0d free=%0d",
                                 i_status, i_alloc_offset, i_free_page_count);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = rsp_queue.pop_front();
                    if (i_status !== e.status || i_alloc_offset !== e.offset ||
                        i_free_page_count !== e.count) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: exp status=%0d off=%0d free=%0d, ",
                                      "got %0d %0d %0d"},
                                     e.status, e.offset, e.count,
                                     i_status, i_alloc_offset, i_free_page_count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/tb_buddy_tree_page_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_tree_page_allocator_top
// Drives alloc and free transactions over several pool sizes, with random
// bursts and output stalls; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_buddy_tree_page_allocator_top;
    import btpa_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_req_type = 1'b0;
    logic [10:0] i_req_pages = '0;
    logic [9:0]  i_block_offset = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [9:0]  o_alloc_offset;
    logic [10:0] o_free_page_count;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int unsigned live_off [$];
    int unsigned live_pg [$];
    int unsigned cur_pool = 1024;
    int          burst_left = 0;

    always #5 i_clk = ~i_clk;

    buddy_tree_page_allocator_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_req_type(i_req_type),
        .i_req_pages(i_req_pages), .i_block_offset(i_block_offset),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_alloc_offset(o_alloc_offset), .o_free_page_count(o_free_page_count)
    );

    buddy_alloc_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_req_fire(i_valid && o_ready), .i_req_type(i_req_type),
        .i_req_pages(i_req_pages), .i_block_offset(i_block_offset),
        .i_rsp_fire(o_valid && i_ready), .i_status(o_status),
        .i_alloc_offset(o_alloc_offset), .i_free_page_count(o_free_page_count),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // End the run when nothing is accepted for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb_buddy_tree_page_allocator_top failed");
            $finish;
        end
    end

    // Remember the sizes of accepted allocations to pair with their offsets.
    int unsigned alloc_sizes [$];
    logic        req_is_alloc [$];
    always @(posedge i_clk) begin
        int unsigned sz;
        logic was_alloc;
        if (i_valid && o_ready) begin
            sz = 1;
            while (sz < i_req_pages) sz <<= 1;
            req_is_alloc.push_back(!i_req_type);
            alloc_sizes.push_back(sz);
        end
        if (o_valid && i_ready && req_is_alloc.size() > 0) begin
            was_alloc = req_is_alloc.pop_front();
            sz = alloc_sizes.pop_front();
            if (was_alloc && o_status == ST_OK) begin
                live_off.push_back(o_alloc_offset);
                live_pg.push_back(sz);
            end
        end
    end

    // Receiver stalls in a pattern of its own: phases of full, mostly high and sparse ready.
    always @(negedge i_clk) begin
        int ph;
        ph = int'(($time / 2000) % 3);
        if (ph == 0) i_ready <= 1'b1;
        else if (ph == 1) i_ready <= ($urandom_range(0, 3) != 0);
        else i_ready <= ($urandom_range(0, 4) == 0);
    end

    task automatic send_req(input logic typ, input logic [10:0] pg, input logic [9:0] off);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 40)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_req_type <= typ;
        i_req_pages <= pg;
        i_block_offset <= off;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        // a following request in the same step raises valid again
        i_valid = 1'b0;
    endtask

    task automatic drain_and_config(input logic [10:0] raw);
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_data <= raw;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        live_off.delete();
        live_pg.delete();
        cur_pool = 1;
        if (raw > 1024) raw = 1024;
        while ((cur_pool << 1) <= raw) cur_pool <<= 1;
    endtask

    task automatic random_phase(input int n);
        int unsigned k, lg, pg, off;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                lg = $urandom_range(0, 3);
                if ($urandom_range(0, 19) == 0) lg = $urandom_range(0, 10);
                pg = 1 << lg;
                if ($urandom_range(0, 3) == 0) pg = $urandom_range(0, pg);
                send_req(1'b0, 11'(pg), 10'($urandom));
            end else if (k < 85 && live_off.size() > 0) begin
                k = $urandom_range(0, live_off.size() - 1);
                pg = live_pg[k];
                if ($urandom_range(0, 1)) pg = $urandom_range(pg / 2 + 1, pg);
                send_req(1'b1, 11'(pg), 10'(live_off[k]));
                live_off.delete(k);
                live_pg.delete(k);
            end else begin
                send_req(1'(k), 11'($urandom_range(0, 2047)), 10'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes and every special case
        send_req(1'b0, 11'd0, 10'h3ff);
        send_req(1'b0, 11'd2047, 10'd0);
        send_req(1'b0, 11'd1024, 10'd0);
        send_req(1'b0, 11'd1, 10'd0);
        send_req(1'b1, 11'd1024, 10'd0);
        send_req(1'b1, 11'd1, 10'd1023);
        send_req(1'b1, 11'd2, 10'd1);
        send_req(1'b1, 11'd1, 10'd1);
        send_req(1'b1, 11'd1024, 10'd0);
        send_req(1'b0, 11'd3, 10'd0);
        send_req(1'b0, 11'd513, 10'd0);
        send_req(1'b1, 11'd4, 10'd4);
        send_req(1'b1, 11'd1, 10'd1022);
        send_req(1'b1, 11'd1024, 10'd0);
        send_req(1'b1, 11'd1, 10'd0);
        send_req(1'b0, 11'd1024, 10'd0);
        send_req(1'b1, 11'd1024, 10'd0);
        drain_and_config(11'd0);
        send_req(1'b0, 11'd1, 10'd0);
        send_req(1'b0, 11'd1, 10'd0);
        send_req(1'b1, 11'd2, 10'd0);
        send_req(1'b1, 11'd1, 10'd0);
        drain_and_config(11'd2047);
        random_phase(200);
        drain_and_config(11'd100);
        random_phase(150);
        drain_and_config(11'd1);
        random_phase(40);
        drain_and_config(11'd1024);
        random_phase(240);
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) $display("tb_buddy_tree_page_allocator_top passed");
        else $display("tb_buddy_tree_page_allocator_top failed");
        $finish;
    end
endmodule
